// ===== rtl/swpt_pkg.sv =====
// shared types and constants for the sliding window percentile tracker
// no dependencies; imported by the cell, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package swpt_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // register indexes on the configuration port
  localparam logic REG_WINDOW_SIZE     = 1'b0;
  localparam logic REG_REPORT_INTERVAL = 1'b1;

  // reset values of the registers
  localparam logic [8:0]  WINDOW_SIZE_RST     = 9'd256;
  localparam logic [15:0] REPORT_INTERVAL_RST = 16'd0;

  // percentile ranks
  localparam logic [6:0] PCT_50 = 7'd50;
  localparam logic [6:0] PCT_90 = 7'd90;
  localparam logic [6:0] PCT_99 = 7'd99;

  // x / 100 as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below about 1.8 million
  localparam int unsigned DIV100_SHIFT = 26;
  localparam logic [19:0] DIV100_MUL   = 20'd671089;

  // command broadcast to every cell of the sorted chain
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_CLEAR,
    CMD_EVICT,
    CMD_INSERT
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/swpt_stream_if.sv =====
// valid/ready stream interfaces for input and result transactions
// depends on nothing beyond fixed field widths
`timescale 1ns / 1ps
`default_nettype none

interface swpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface swpt_out_if;
  logic        valid;
  logic        ready;
  logic        auto_report;
  logic [8:0]  sample_count;
  logic [63:0] min_value;
  logic [63:0] median_value;
  logic [63:0] p90_value;
  logic [63:0] p99_value;
  logic [63:0] max_value;

  modport source (output valid, output auto_report, output sample_count, output min_value,
                  output median_value, output p90_value, output p99_value, output max_value,
                  input ready);
  modport sink   (input valid, input auto_report, input sample_count, input min_value,
                  input median_value, input p90_value, input p99_value, input max_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/swpt_cell.sv =====
// one cell of the sorted chain: holds a key {value, ring slot} and a valid bit
// depends on swpt_pkg; neighbors exchange keys on evict and insert commands
`timescale 1ns / 1ps
`default_nettype none

module swpt_cell #(
  parameter int KEY_W = 72
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  swpt_pkg::cell_cmd_t   cmd,
  input  wire [KEY_W-1:0]       key_in,
  input  wire                   left_gt,
  input  wire [KEY_W-1:0]       left_key,
  input  wire                   left_vld,
  input  wire [KEY_W-1:0]       right_key,
  input  wire                   right_vld,
  output logic                  gt,
  output logic [KEY_W-1:0]      key_q,
  output logic                  vld_q
);
  import swpt_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic             vld_r;
  logic             ge;

  // empty cells sort after everything
  assign gt    = !vld_r || (key_r > key_in);
  assign ge    = !vld_r || (key_r >= key_in);
  assign key_q = key_r;
  assign vld_q = vld_r;

  // payload moves with its neighbors
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_EVICT: begin
        if (ge) begin
          key_r <= right_key;
        end
      end
      CMD_INSERT: begin
        if (gt) begin
          key_r <= left_gt ? left_key : key_in;
        end
      end
      default: begin
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_CLEAR: vld_r <= 1'b0;
        CMD_EVICT: begin
          if (ge) begin
            vld_r <= right_vld;
          end
        end
        CMD_INSERT: begin
          if (gt) begin
            vld_r <= left_gt ? left_vld : 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_percentile_tracker_core.sv =====
// top level of the sliding window percentile tracker
// depends on swpt_pkg, swpt_stream_if and swpt_cell
`timescale 1ns / 1ps
`default_nettype none

// One transaction at a time: the input is ready only while the control state
// machine is idle. A record evicts from the sorted chain, inserts, and loads the
// output register with a count-only result; a record that triggers a report adds
// a rank multiply, a divide by 100 and the rank selects S_SEL (three ranks) and
// S_SEL2 (two ranks) before the load. A query runs multiply, divide, both selects
// and the output load; a clear goes straight to the load. The next transaction
// is taken only after the result is loaded, which waits on out_ch.ready. The
// sorted chain of WINDOW_DEPTH cells shifts one step per evict or insert, and the
// ring memory gives the value being overwritten in the cycle after the read. No
// clearing pass.
module sliding_window_percentile_tracker_core #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  swpt_in_if.sink     in_ch,
  swpt_out_if.source  out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swpt_pkg::*;

  localparam int TAG_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int KEY_W  = SAMPLE_BITS + TAG_W;
  localparam int PROD_W = CNT_W + 7;

  typedef enum logic [2:0] {
    S_IDLE, S_EVICT, S_INSERT, S_MUL, S_DIV, S_SEL, S_SEL2, S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [8:0]  win_size_r;
  logic [15:0] rep_int_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_REPORT_INTERVAL) begin
      prdata = {16'd0, rep_int_r};
    end else begin
      prdata = {23'd0, win_size_r};
    end
  end

  // effective window length
  logic [CNT_W-1:0] cap;
  always_comb begin
    if (win_size_r == 9'd0 || 32'(win_size_r) > 32'(WINDOW_DEPTH)) begin
      cap = CNT_W'(WINDOW_DEPTH);
    end else begin
      cap = CNT_W'(win_size_r);
    end
  end

  logic [TAG_W-1:0] wp_r;
  logic [CNT_W-1:0] fill_r;
  logic [15:0]      rec_cnt_r;

  // slot for the next record
  logic [TAG_W-1:0] pos;
  logic [CNT_W-1:0] pos_inc;
  assign pos     = (CNT_W'(wp_r) >= cap) ? '0 : wp_r;
  assign pos_inc = CNT_W'(pos) + CNT_W'(1);

  // transaction capture
  logic                   accept;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [TAG_W-1:0]       pos_r;
  logic [TAG_W-1:0]       pos_nxt_r;
  logic                   full_r;
  logic                   report_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // sample ring memory
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] ring_rd_r;

  always_ff @(posedge clk) begin
    if (state_r == S_EVICT) begin
      ring_mem[pos_r] <= smp_r;
    end
    ring_rd_r <= ring_mem[pos];
  end

  // sorted chain
  cell_cmd_t        cmd;
  logic [KEY_W-1:0] bkey;
  logic [KEY_W-1:0] ck [WINDOW_DEPTH];
  logic             cv [WINDOW_DEPTH];
  logic             cg [WINDOW_DEPTH];

  always_comb begin
    cmd  = CMD_HOLD;
    bkey = {smp_r, pos_r};
    if (state_r == S_IDLE && accept && in_ch.opcode == OP_CLEAR) begin
      cmd = CMD_CLEAR;
    end else if (state_r == S_IDLE && cfg_wr && paddr[2] == REG_WINDOW_SIZE) begin
      cmd = CMD_CLEAR;
    end else if (state_r == S_EVICT && full_r) begin
      cmd  = CMD_EVICT;
      bkey = {ring_rd_r, pos_r};
    end else if (state_r == S_INSERT) begin
      cmd = CMD_INSERT;
    end
  end

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic             l_gt;
    logic [KEY_W-1:0] l_key;
    logic             l_vld;
    logic [KEY_W-1:0] r_key;
    logic             r_vld;
    if (i == 0) begin : g_first
      assign l_gt  = 1'b0;
      assign l_key = '0;
      assign l_vld = 1'b0;
    end else begin : g_mid
      assign l_gt  = cg[i-1];
      assign l_key = ck[i-1];
      assign l_vld = cv[i-1];
    end
    if (i == WINDOW_DEPTH - 1) begin : g_last
      assign r_key = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_key = ck[i+1];
      assign r_vld = cv[i+1];
    end
    swpt_cell #(.KEY_W(KEY_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .key_in    (bkey),
      .left_gt   (l_gt),
      .left_key  (l_key),
      .left_vld  (l_vld),
      .right_key (r_key),
      .right_vld (r_vld),
      .gt        (cg[i]),
      .key_q     (ck[i]),
      .vld_q     (cv[i])
    );
  end

  // rank arithmetic
  logic [PROD_W-1:0] p50_r, p90_r, p99_r;
  logic [TAG_W-1:0]  i50_r, i90_r, i99_r, imax_r;
  logic [PROD_W+19:0] q50, q90, q99;
  assign q50 = (PROD_W+20)'(p50_r) * (PROD_W+20)'(DIV100_MUL);
  assign q90 = (PROD_W+20)'(p90_r) * (PROD_W+20)'(DIV100_MUL);
  assign q99 = (PROD_W+20)'(p99_r) * (PROD_W+20)'(DIV100_MUL);

  // result staging and output register
  logic                   res_rep_r;
  logic [8:0]             res_cnt_r;
  logic [SAMPLE_BITS-1:0] res_min_r, res_med_r, res_p90_r, res_p99_r, res_max_r;
  logic                   out_valid_r;
  logic                   out_rep_r;
  logic [8:0]             out_cnt_r;
  logic [63:0]            out_min_r, out_med_r, out_p90_r, out_p99_r, out_max_r;
  logic [15:0]            rec_inc;
  assign rec_inc = rec_cnt_r + 16'd1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.auto_report  = out_rep_r;
  assign out_ch.sample_count = out_cnt_r;
  assign out_ch.min_value    = out_min_r;
  assign out_ch.median_value = out_med_r;
  assign out_ch.p90_value    = out_p90_r;
  assign out_ch.p99_value    = out_p99_r;
  assign out_ch.max_value    = out_max_r;

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          smp_r     <= SAMPLE_BITS'(in_ch.sample);
          pos_r     <= pos;
          pos_nxt_r <= (pos_inc >= cap) ? '0 : TAG_W'(pos_inc);
          full_r    <= (fill_r == cap);
          res_rep_r <= 1'b0;
          res_cnt_r <= 9'd0;
          res_min_r <= '0;
          res_med_r <= '0;
          res_p90_r <= '0;
          res_p99_r <= '0;
          res_max_r <= '0;
        end
      end
      S_EVICT: begin
        report_r <= (rep_int_r != 16'd0) && (rec_inc >= rep_int_r);
      end
      S_INSERT: begin
        res_cnt_r <= 9'(fill_r);
        res_rep_r <= report_r;
      end
      S_MUL: begin
        res_cnt_r <= 9'(fill_r);
        p50_r     <= PROD_W'(fill_r) * PROD_W'(PCT_50);
        p90_r     <= PROD_W'(fill_r) * PROD_W'(PCT_90);
        p99_r     <= PROD_W'(fill_r) * PROD_W'(PCT_99);
        imax_r    <= TAG_W'(fill_r - CNT_W'(1));
      end
      S_DIV: begin
        i50_r <= TAG_W'(q50 >> DIV100_SHIFT);
        i90_r <= TAG_W'(q90 >> DIV100_SHIFT);
        i99_r <= TAG_W'(q99 >> DIV100_SHIFT);
      end
      // ranks from the chain: min, median and p90, then p99 and max
      S_SEL: begin
        if (fill_r != '0) begin
          res_min_r <= ck[0][KEY_W-1:TAG_W];
          res_med_r <= ck[i50_r][KEY_W-1:TAG_W];
          res_p90_r <= ck[i90_r][KEY_W-1:TAG_W];
        end
      end
      S_SEL2: begin
        if (fill_r != '0) begin
          res_p99_r <= ck[i99_r][KEY_W-1:TAG_W];
          res_max_r <= ck[imax_r][KEY_W-1:TAG_W];
        end
      end
      default: begin
      end
    endcase
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_rep_r <= res_rep_r;
      out_cnt_r <= res_cnt_r;
      out_min_r <= 64'(res_min_r);
      out_med_r <= 64'(res_med_r);
      out_p90_r <= 64'(res_p90_r);
      out_p99_r <= 64'(res_p99_r);
      out_max_r <= 64'(res_max_r);
    end
  end

  // control state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_size_r  <= WINDOW_SIZE_RST;
      rep_int_r   <= REPORT_INTERVAL_RST;
      wp_r        <= '0;
      fill_r      <= '0;
      rec_cnt_r   <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_wr) begin
            if (paddr[2] == REG_WINDOW_SIZE) begin
              win_size_r <= pwdata[8:0];
              fill_r     <= '0;
              wp_r       <= '0;
            end else begin
              rep_int_r <= pwdata[15:0];
            end
          end
          if (accept) begin
            priority case (in_ch.opcode)
              OP_RECORD: state_r <= S_EVICT;
              OP_CLEAR: begin
                fill_r    <= '0;
                wp_r      <= '0;
                rec_cnt_r <= 16'd0;
                state_r   <= S_DONE;
              end
              default: state_r <= S_MUL;
            endcase
          end
        end
        S_EVICT: begin
          wp_r <= pos_nxt_r;
          if (!full_r) begin
            fill_r <= fill_r + CNT_W'(1);
          end
          if ((rep_int_r != 16'd0) && (rec_inc >= rep_int_r)) begin
            rec_cnt_r <= 16'd0;
          end else begin
            rec_cnt_r <= rec_inc;
          end
          state_r <= S_INSERT;
        end
        S_INSERT: state_r <= report_r ? S_MUL : S_DONE;
        S_MUL:    state_r <= S_DIV;
        S_DIV:    state_r <= S_SEL;
        S_SEL:    state_r <= S_SEL2;
        S_SEL2:   state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // fill count never exceeds the chain length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(WINDOW_DEPTH))
    else $error("fill count above window depth");

  // head cell holds data exactly when the window is not empty, between transactions
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cv[0] == (fill_r != '0)))
    else $error("sorted chain head disagrees with fill count");

  // a clear empties the window on the next cycle
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.opcode == OP_CLEAR) |=> (fill_r == '0 && !cv[0]))
    else $error("clear left samples in the window");

endmodule

`default_nettype wire

// ===== tb/sliding_window_percentile_tracker_core_tb.sv =====
// self-checking testbench for the sliding window percentile tracker core
// depends on swpt_pkg, swpt_stream_if and the core; drives the apb port and both streams
`timescale 1ns / 1ps

module sliding_window_percentile_tracker_core_tb;
  import swpt_pkg::*;

  localparam int DEPTH = 256;

  // unused opcode, handled as a query
  localparam logic [1:0] OP_QUERY_ALT = 2'd3;

  typedef struct packed {
    logic        auto_report;
    logic [8:0]  sample_count;
    logic [63:0] min_value;
    logic [63:0] median_value;
    logic [63:0] p90_value;
    logic [63:0] p99_value;
    logic [63:0] max_value;
  } stats_t;

  typedef struct {
    logic [1:0]  opcode;
    logic [63:0] sample;
    bit          has_exp;
    stats_t      exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  swpt_in_if  in_ch ();
  swpt_out_if out_ch ();

  sliding_window_percentile_tracker_core #(.WINDOW_DEPTH(DEPTH), .SAMPLE_BITS(64)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [63:0] ring_q [DEPTH];
  int unsigned wr_pos, held, rec_count, win_reg, interval_reg;
  stats_t expected_stats [$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int n_results = 0, n_reports = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_QUERY;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned eff_window();
    if (win_reg == 0 || win_reg > DEPTH) return DEPTH;
    return win_reg;
  endfunction

  function automatic int unsigned rank(int unsigned n, int unsigned pct);
    int unsigned idx;
    idx = (n * pct) / 100;
    if (idx >= n) idx = n - 1;
    return idx;
  endfunction

  function automatic stats_t window_stats(logic auto_flag);
    stats_t s;
    logic [63:0] srt [$];
    s = '0;
    s.auto_report = auto_flag;
    s.sample_count = held[8:0];
    if (held == 0) return s;
    for (int i = 0; i < held; i++) srt.push_back(ring_q[i]);
    srt.sort();
    s.min_value = srt[0];
    s.median_value = srt[rank(held, 50)];
    s.p90_value = srt[rank(held, 90)];
    s.p99_value = srt[rank(held, 99)];
    s.max_value = srt[held - 1];
    return s;
  endfunction

  // advance the predictor by one accepted transaction
  function automatic stats_t predict_stats(logic [1:0] op, logic [63:0] smp);
    stats_t s;
    int unsigned cap, pos;
    s = '0;
    cap = eff_window();
    if (op == OP_RECORD) begin
      pos = (wr_pos >= cap) ? 0 : wr_pos;
      ring_q[pos] = smp;
      pos++;
      wr_pos = (pos >= cap) ? 0 : pos;
      if (held < cap) held++;
      rec_count = (rec_count + 1) & 16'hFFFF;
      if (interval_reg > 0 && rec_count >= interval_reg) begin
        rec_count = 0;
        s = window_stats(1'b1);
      end else begin
        s.sample_count = held[8:0];
      end
    end else if (op == OP_CLEAR) begin
      held = 0;
      wr_pos = 0;
      rec_count = 0;
    end else begin
      s = window_stats(1'b0);
    end
    return s;
  endfunction

  // apb register write: setup then access
  task automatic reg_write(logic reg_idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_idx == REG_WINDOW_SIZE) begin
      win_reg = value & 9'h1FF;
      held = 0;
      wr_pos = 0;
    end else begin
      interval_reg = value & 16'hFFFF;
    end
  endtask

  // send one transaction, queueing the prediction or a typed expectation
  task automatic send_item(logic [1:0] op, logic [63:0] smp, bit has_exp, stats_t typed);
    stats_t p;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.sample <= smp;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    p = predict_stats(op, smp);
    if (has_exp && typed != p) begin
      $error("directed row disagrees with predictor: exp %h pred %h", typed, p);
      errors++;
    end
    expected_stats.push_back(has_exp ? typed : p);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver ready and result checking
  always @(posedge clk) begin
    stats_t got, e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.auto_report, out_ch.sample_count, out_ch.min_value,
                out_ch.median_value, out_ch.p90_value, out_ch.p99_value, out_ch.max_value};
        n_results++;
        if (got.auto_report) n_reports++;
        if (expected_stats.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = expected_stats.pop_front();
          if (got.auto_report !== e.auto_report) begin
            $error("auto_report exp %0d got %0d", e.auto_report, got.auto_report); errors++;
          end
          if (got.sample_count !== e.sample_count) begin
            $error("sample_count exp %0d got %0d", e.sample_count, got.sample_count); errors++;
          end
          if (got.min_value !== e.min_value) begin
            $error("min_value exp %h got %h", e.min_value, got.min_value); errors++;
          end
          if (got.median_value !== e.median_value) begin
            $error("median_value exp %h got %h", e.median_value, got.median_value); errors++;
          end
          if (got.p90_value !== e.p90_value) begin
            $error("p90_value exp %h got %h", e.p90_value, got.p90_value); errors++;
          end
          if (got.p99_value !== e.p99_value) begin
            $error("p99_value exp %h got %h", e.p99_value, got.p99_value); errors++;
          end
          if (got.max_value !== e.max_value) begin
            $error("max_value exp %h got %h", e.max_value, got.max_value); errors++;
          end
        end
      end
    end
    out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  function automatic logic [63:0] rand_sample();
    case ($urandom_range(3, 0))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(50, 0));
      2: return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15, 0));
      default: return {32'h0, $urandom};
    endcase
  endfunction

  // random phase: mostly records, some queries, rare clears and opcode three
  task automatic random_phase(int count);
    int r;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99, 0);
      op = (r < 70) ? OP_RECORD : (r < 93) ? OP_QUERY : (r < 97) ? OP_CLEAR : OP_QUERY_ALT;
      send_item(op, rand_sample(), 1'b0, '0);
    end
  endtask

  stim_row_t rows [$];

  task automatic add_row(logic [1:0] op, logic [63:0] smp, bit has_exp, stats_t e);
    stim_row_t r;
    r.opcode = op; r.sample = smp; r.has_exp = has_exp; r.exp = e;
    rows.push_back(r);
  endtask

  initial begin
    wr_pos = 0; held = 0; rec_count = 0;
    win_reg = WINDOW_SIZE_RST; interval_reg = REPORT_INTERVAL_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty window, extremes, opcode three, clear
    add_row(OP_QUERY, '0, 1'b1, '0);
    add_row(OP_QUERY_ALT, '0, 1'b1, '0);
    add_row(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 9'd1, 0, 0, 0, 0, 0});
    add_row(OP_RECORD, 64'h0, 1'b1, '{1'b0, 9'd2, 0, 0, 0, 0, 0});
    add_row(OP_QUERY, '0, 1'b1, '{1'b0, 9'd2, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
    add_row(OP_RECORD, 64'h5555_5555_5555_5555, 1'b0, '0);
    add_row(OP_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
    add_row(OP_QUERY_ALT, '0, 1'b0, '0);
    add_row(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0);
    add_row(OP_QUERY, '0, 1'b1, '0);
    foreach (rows[i]) send_item(rows[i].opcode, rows[i].sample, rows[i].has_exp, rows[i].exp);
    wait_drained();

    // window of one with a report on every record
    reg_write(REG_WINDOW_SIZE, 32'd1);
    reg_write(REG_REPORT_INTERVAL, 32'd1);
    send_item(OP_RECORD, 64'd7, 1'b1, '{1'b1, 9'd1, 64'd7, 64'd7, 64'd7, 64'd7, 64'd7});
    send_item(OP_RECORD, 64'd3, 1'b0, '0);
    send_item(OP_QUERY, '0, 1'b0, '0);
    wait_drained();

    // interval lowered below the counter, and a window size of zero
    reg_write(REG_WINDOW_SIZE, 32'd0);
    reg_write(REG_REPORT_INTERVAL, 32'd10);
    for (int i = 0; i < 5; i++) send_item(OP_RECORD, rand_sample(), 1'b0, '0);
    wait_drained();
    reg_write(REG_REPORT_INTERVAL, 32'd2);
    send_item(OP_RECORD, 64'd1, 1'b0, '0);
    wait_drained();

    // random phases over several settings
    send_idle_pct = 14; recv_idle_pct = 45;
    reg_write(REG_WINDOW_SIZE, 32'd5);
    reg_write(REG_REPORT_INTERVAL, 32'd3);
    random_phase(250);
    wait_drained();

    send_idle_pct = 45; recv_idle_pct = 14;
    reg_write(REG_WINDOW_SIZE, 32'd300);
    reg_write(REG_REPORT_INTERVAL, 32'd17);
    random_phase(350);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    reg_write(REG_WINDOW_SIZE, 32'd256);
    reg_write(REG_REPORT_INTERVAL, 32'd65535);
    random_phase(200);
    wait_drained();
    reg_write(REG_WINDOW_SIZE, 32'd37);
    reg_write(REG_REPORT_INTERVAL, 32'd0);
    random_phase(200);
    wait_drained();
    reg_write(REG_WINDOW_SIZE, 32'd2);
    reg_write(REG_REPORT_INTERVAL, 32'd4);
    random_phase(200);
    wait_drained();

    $display("covered %0d results, %0d automatic reports, window sizes 0..300, intervals 0..65535",
             n_results, n_reports);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
